@@ rtl/erseq_pkg.sv @@
package erseq_pkg;

  localparam int TRACK_COUNT = 8;
  localparam int MAX_STEPS   = 16;

  localparam int MASK_W     = 8;
  localparam int STEP_W     = 24;
  localparam int PATTERN_W  = 14;
  localparam int CFG_ADDR_W = 8;

  localparam int NF_W = 5;
  localparam int KF_W = 5;
  localparam int R_W  = 4;

  localparam logic [PATTERN_W-1:0] RESET_PATTERN = PATTERN_W'(144);

  localparam int TRK_W  = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int N_W    = $clog2(MAX_STEPS + 1);
  localparam int REM_W  = $clog2(MAX_STEPS);
  localparam int PROD_W = REM_W + N_W;
  localparam int X_W    = STEP_W + 1;
  localparam int CNT_W  = $clog2(X_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MUL,
    S_RED,
    S_NEXT,
    S_DONE
  } state_t;

endpackage

@@ rtl/euclidean_rhythm_sequencer.sv @@
// A new step raises its trigger mask once every track has been visited in turn; a silent
// track goes straight to the next, an active one runs divide, multiply and reduce on one
// shared remainder unit. The next request is taken only once the sweep is done and the
// previous mask has been taken; a repeated step number is accepted while idle and starts no work.
// Reset clears the sequencer, the last-step record and the output valid flag, and sets
// every track pattern to sixteen steps, four triggers, no rotation.
module euclidean_rhythm_sequencer
  import erseq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step_valid,
  output logic                  step_ready,
  input  logic [STEP_W-1:0]     step_count,
  output logic                  trig_valid,
  input  logic                  trig_ready,
  output logic [MASK_W-1:0]     trigger_mask,
  output logic [STEP_W-1:0]     step_echo,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [PATTERN_W-1:0]  cfg_data
);

  state_t state, state_next;

  logic [PATTERN_W-1:0]   pattern [TRACK_COUNT];
  logic [STEP_W-1:0]      last_step;
  logic                   last_valid;
  logic [STEP_W-1:0]      cur_step;
  logic [TRK_W-1:0]       trk;
  logic [N_W-1:0]         n;
  logic [N_W-1:0]         k;
  logic                   active;
  logic [X_W-1:0]         sh;
  logic [REM_W-1:0]       rem;
  logic [CNT_W-1:0]       cnt;
  logic [TRACK_COUNT-1:0] fires;

  logic [NF_W-1:0]        nf;
  logic [KF_W-1:0]        kf;
  logic [R_W-1:0]         rf;
  logic [N_W-1:0]         n_sat;
  logic [N_W-1:0]         k_clamp;
  logic [REM_W:0]         shifted;
  logic [REM_W-1:0]       rem_step;
  logic [MASK_W-1:0]      mask_value;
  logic                   accept;
  logic                   repeat_step;
  logic                   out_free;
  logic                   load_out;
  logic                   last_track;

  assign accept      = step_valid && step_ready;
  assign repeat_step = last_valid && (step_count == last_step);
  assign out_free    = !trig_valid || trig_ready;
  assign last_track  = (trk == TRK_W'(TRACK_COUNT - 1));
  assign cfg_ready   = 1'b1;

  // Field decode and clamping of the track currently visited.
  always_comb begin
    nf = pattern[trk][NF_W-1:0];
    kf = pattern[trk][NF_W+KF_W-1:NF_W];
    rf = pattern[trk][NF_W+KF_W+R_W-1:NF_W+KF_W];
    if (32'(nf) > MAX_STEPS) begin
      n_sat = N_W'(MAX_STEPS);
    end else begin
      n_sat = N_W'(nf);
    end
    if (32'(kf) > 32'(n_sat)) begin
      k_clamp = n_sat;
    end else begin
      k_clamp = N_W'(kf);
    end
  end

  // Shared remainder step: bring in one bit, subtract n if it fits.
  always_comb begin
    shifted = {rem, sh[X_W-1]};
    if (shifted >= (REM_W+1)'(n)) begin
      rem_step = REM_W'(shifted - (REM_W+1)'(n));
    end else begin
      rem_step = REM_W'(shifted);
    end
  end

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      mask_value[i] = (i < TRACK_COUNT) ? fires[i % TRACK_COUNT] : 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (step_valid && !repeat_step) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (n_sat == '0 || k_clamp == '0) begin
          state_next = S_NEXT;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt == '0) begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_RED;
      S_RED: begin
        if (cnt == '0) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (last_track) begin
          state_next = S_DONE;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    step_ready = (state == S_IDLE);
    load_out   = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRACK_COUNT; i++) begin
        pattern[i] <= RESET_PATTERN;
      end
    end else if (cfg_valid && cfg_ready && (cfg_addr < CFG_ADDR_W'(TRACK_COUNT))) begin
      pattern[cfg_addr[TRK_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_step  <= '0;
      last_valid <= 1'b0;
    end else if (accept && !repeat_step) begin
      last_step  <= step_count;
      last_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_valid <= 1'b0;
    end else if (load_out) begin
      trig_valid <= 1'b1;
    end else if (trig_ready) begin
      trig_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      trigger_mask <= mask_value;
      step_echo    <= cur_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trk <= '0;
    end else begin
      unique case (state)
        S_IDLE: trk <= '0;
        S_NEXT: begin
          if (!last_track) begin
            trk <= trk + TRK_W'(1);
          end
        end
        S_LOAD, S_DIV, S_MUL, S_RED, S_DONE: trk <= trk;
        default: trk <= '0;
      endcase
    end
  end

  // The remainder of s + 16n - r by n equals ((s mod n) - r) mod n.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur_step <= step_count;
        end
      end
      S_LOAD: begin
        n      <= n_sat;
        k      <= k_clamp;
        active <= (n_sat != '0) && (k_clamp != '0);
        sh     <= {1'b0, cur_step} + (X_W'(n_sat) << R_W) - X_W'(rf);
        rem    <= '0;
        cnt    <= CNT_W'(X_W - 1);
      end
      S_DIV, S_RED: begin
        rem <= rem_step;
        sh  <= sh << 1;
        cnt <= cnt - CNT_W'(1);
      end
      S_MUL: begin
        sh  <= {PROD_W'(rem) * PROD_W'(k), (X_W-PROD_W)'(0)};
        rem <= '0;
        cnt <= CNT_W'(PROD_W - 1);
      end
      S_NEXT: begin
        fires[trk] <= active && (N_W'(rem) < k);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_rem_below_n: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV || state == S_RED) |-> ((N_W+1)'(rem) < (N_W+1)'(n)))
    else $error("remainder not below step count");

  a_new_step_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && !repeat_step) |=> (state == S_LOAD && trk == '0))
    else $error("new step did not start the track sweep");

  a_repeat_no_work: assert property (@(posedge clk) disable iff (rst)
    (accept && repeat_step) |=> (state == S_IDLE))
    else $error("repeated step started work");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(trig_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the done state");

  a_trk_range: assert property (@(posedge clk) disable iff (rst)
    (32'(trk) < TRACK_COUNT))
    else $error("track index out of range");
`endif

endmodule

@@ bench/tb.sv @@
module tb
  import erseq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 400;
  localparam int RANDOM_ITEMS = 530;
  localparam int PRESSURE_CYCLES = 2000;

  typedef struct {
    logic [MASK_W-1:0] mask;
    logic [STEP_W-1:0] step;
  } trigger_t;

  class trigger_scoreboard;
    logic [PATTERN_W-1:0] pattern[TRACK_COUNT];
    logic [STEP_W-1:0] last_step;
    bit step_seen;
    trigger_t pending[$];
    int mismatches;

    function new();
      foreach (pattern[t]) pattern[t] = RESET_PATTERN;
      last_step = '0;
      step_seen = 0;
      mismatches = 0;
    endfunction

    function void write_pattern(int idx, logic [PATTERN_W-1:0] data);
      if (idx < TRACK_COUNT) pattern[idx] = data;
    endfunction

    function logic [MASK_W-1:0] fire_mask(logic [STEP_W-1:0] s);
      logic [MASK_W-1:0] mask;
      int unsigned n;
      int unsigned k;
      int unsigned r;
      int unsigned pos;
      mask = '0;
      for (int t = 0; t < TRACK_COUNT && t < MASK_W; t++) begin
        n = pattern[t][4:0];
        k = pattern[t][9:5];
        r = pattern[t][13:10];
        if (n > MAX_STEPS) n = MAX_STEPS;
        if (n != 0 && k != 0) begin
          if (k > n) k = n;
          r = r % n;
          pos = ((s % n) + n - r) % n;
          if ((pos * k) % n < k) mask[t] = 1'b1;
        end
      end
      return mask;
    endfunction

    function bit note_step(logic [STEP_W-1:0] s);
      trigger_t want;
      if (step_seen && s == last_step) return 0;
      last_step = s;
      step_seen = 1;
      want.mask = fire_mask(s);
      want.step = s;
      pending = {pending, want};
      return 1;
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    endfunction

    function void check_trigger(logic [MASK_W-1:0] mask, logic [STEP_W-1:0] echo);
      trigger_t want;
      if (pending.size() == 0) begin
        flag("unrequested trigger (step_echo)", 0, echo);
        return;
      end
      want = pending.pop_front();
      if (mask !== want.mask) flag("trigger_mask", want.mask, mask);
      if (echo !== want.step) flag("step_echo", want.step, echo);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic step_valid;
  logic step_ready;
  logic [STEP_W-1:0] step_count;
  logic trig_valid;
  logic trig_ready;
  logic [MASK_W-1:0] trigger_mask;
  logic [STEP_W-1:0] step_echo;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [PATTERN_W-1:0] cfg_data;

  trigger_scoreboard sb = new();
  int triggers_seen = 0;
  bit sender_quiet = 0;

  euclidean_rhythm_sequencer dut (
    .clk(clk),
    .rst(rst),
    .step_valid(step_valid),
    .step_ready(step_ready),
    .step_count(step_count),
    .trig_valid(trig_valid),
    .trig_ready(trig_ready),
    .trigger_mask(trigger_mask),
    .step_echo(step_echo),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [PATTERN_W-1:0] pack_pattern(int n, int k, int r);
    return {r[3:0], k[4:0], n[4:0]};
  endfunction

  task automatic send_step(input logic [STEP_W-1:0] s);
    int gap;
    if ($urandom_range(0, 19) == 0) sender_quiet = !sender_quiet;
    gap = (sender_quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      step_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    step_valid <= 1'b1;
    step_count <= s;
    do @(posedge clk); while (!step_ready);
    void'(sb.note_step(s));
  endtask

  task automatic write_reg(input int idx, input logic [PATTERN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr <= CFG_ADDR_W'(idx);
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_pattern(idx, data);
  endtask

  // Results never come for repeated steps, so the block may still be busy
  // when the queue drains; allow a full track sweep before touching registers.
  task automatic settle();
    step_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int mode);
    int n;
    logic [PATTERN_W-1:0] data;
    for (int t = 0; t < TRACK_COUNT; t++) begin
      case (mode)
        0: data = '0;
        1: data = '1;
        2: data = PATTERN_W'($urandom_range(0, 16383));
        default: begin
          n = $urandom_range(1, MAX_STEPS);
          data = pack_pattern(n, $urandom_range(0, n), $urandom_range(0, 15));
        end
      endcase
      write_reg(t, data);
    end
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(TRACK_COUNT, 255), PATTERN_W'($urandom_range(0, 16383)));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int stall_left;
    bit receiver_quiet;
    bit pressured;
    stall_left = 0;
    receiver_quiet = 0;
    pressured = 0;
    trig_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && trig_valid && trig_ready) begin
        sb.check_trigger(trigger_mask, step_echo);
        triggers_seen++;
      end
      if ($urandom_range(0, 199) == 0) receiver_quiet = !receiver_quiet;
      if (stall_left > 0) begin
        stall_left--;
        trig_ready <= 1'b0;
      end else if (!pressured && triggers_seen >= 150 && step_valid) begin
        pressured = 1;
        stall_left = PRESSURE_CYCLES;
        trig_ready <= 1'b0;
      end else if (!receiver_quiet && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap() - 1;
        trig_ready <= 1'b0;
      end else begin
        trig_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [STEP_W-1:0] directed_a [10];
    logic [STEP_W-1:0] directed_b [11];
    logic [STEP_W-1:0] cur_step;
    int random_items;
    int phase;
    int items;
    int roll;
    int wait_cycles;

    directed_a = '{24'd0, 24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd16,
                   24'hFFFFFF, 24'hFFFFFF, 24'h800000};
    directed_b = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd5, 24'd7, 24'd11,
                   24'd13, 24'd14, 24'd15, 24'h123456};
    rst = 1'b1;
    step_valid = 1'b0;
    step_count = '0;
    cfg_valid = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_a[i]) send_step(directed_a[i]);
    settle();

    write_reg(0, pack_pattern(0, 5, 0));
    write_reg(1, pack_pattern(5, 0, 2));
    write_reg(2, pack_pattern(3, 7, 0));
    write_reg(3, pack_pattern(31, 5, 3));
    write_reg(4, pack_pattern(5, 2, 13));
    write_reg(5, pack_pattern(16, 16, 15));
    write_reg(6, '1);
    write_reg(7, pack_pattern(1, 1, 0));
    write_reg(TRACK_COUNT, '0);
    write_reg(255, '0);
    cfg_valid <= 1'b0;
    @(posedge clk);
    foreach (directed_b[i]) send_step(directed_b[i]);

    random_items = 0;
    phase = 0;
    cur_step = STEP_W'($urandom);
    while (random_items < RANDOM_ITEMS) begin
      settle();
      configure(phase < 2 ? phase : $urandom_range(2, 3));
      items = $urandom_range(40, 80);
      for (int i = 0; i < items && random_items < RANDOM_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 30) cur_step = cur_step;
        else if (roll < 75) cur_step = cur_step + 1'b1;
        else if (roll < 85) cur_step = cur_step + STEP_W'($urandom_range(2, 40));
        else cur_step = STEP_W'($urandom);
        send_step(cur_step);
        random_items++;
      end
      phase++;
    end

    step_valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.flag("missing triggers (count)", 0, sb.pending.size());

    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/erseq_pkg.sv
rtl/euclidean_rhythm_sequencer.sv
bench/tb.sv
